[src/mbd_pkg.sv]
`default_nettype none
package mbd_pkg;

  // Register and field widths fixed by the block's interface
  localparam int CFG_W        = 13;
  localparam int CHAN_W       = 8;
  localparam int PAIR_W       = CHAN_W + 1;
  localparam int NUM_CHAN     = 4;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;
  localparam int Y_W          = 11;

  // Queue depths between the parts
  localparam int JOB_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_index_t;

  // Work that the front hands to the back
  typedef enum logic [1:0] {
    JOB_WRITE  = 2'd0,
    JOB_DIRECT = 2'd1,
    JOB_READ   = 2'd2
  } job_kind_t;

  typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] texel_t;

  typedef struct packed {
    job_kind_t kind;
    logic      end_of_row;
    logic      last;
    pair_t     pair;
  } job_t;

  typedef struct packed {
    texel_t texel;
    logic   end_of_row;
    logic   last;
  } result_t;

endpackage
`default_nettype wire

[src/mbd_queue.sv]
`default_nettype none
module mbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Store incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/mbd_front.sv]
`default_nettype none
module mbd_front #(
  parameter int MAX_WIDTH = 4096,
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1,
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int WD_W = $clog2(MAX_WIDTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  mbd_pkg::texel_t          texel_in,
  input  logic                     cfg_write,
  input  mbd_pkg::cfg_index_t      cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0] cfg_data,
  input  logic                     job_full,
  output logic                     job_push,
  output mbd_pkg::job_t            job,
  output logic [ADDR_W-1:0]        job_x
);
  import mbd_pkg::*;

  // Geometry derived at register write
  logic [WD_W-1:0]   width_eff;
  logic              width_one;
  logic [ADDR_W-1:0] tw_m1;
  logic [CFG_W-1:0]  height_eff;
  logic              height_one;
  logic [Y_W-1:0]    th_m1;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  texel_t            left_texel;

  logic [WD_W-1:0]   width_new;
  logic [CFG_W-1:0]  height_new;
  logic              accept;
  logic [WD_W-1:0]   col_inc;
  logic [CFG_W-1:0]  row_inc;
  logic [COL_W-1:0]  x_full;
  logic [ROW_W-1:0]  y_full;
  logic              have_pair;
  logic              gen;
  logic              y_last;
  pair_t             pair;
  logic [ADDR_W-1:0] x;
  job_kind_t         kind;

  // Clamp incoming register values
  always_comb begin
    if (cfg_data == '0) begin
      width_new = WD_W'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      width_new = WD_W'(MAX_WIDTH);
    end else begin
      width_new = WD_W'(cfg_data);
    end
    if (cfg_data == '0) begin
      height_new = CFG_W'(1);
    end else if (int'(cfg_data) > HEIGHT_LIMIT) begin
      height_new = CFG_W'(HEIGHT_LIMIT);
    end else begin
      height_new = cfg_data;
    end
  end

  // Classify the incoming texel
  always_comb begin
    accept    = push && !job_full;
    x_full    = column_count >> 1;
    y_full    = row_count >> 1;
    have_pair = 1'b0;
    gen       = 1'b0;
    y_last    = 1'b0;
    x         = '0;
    kind      = JOB_WRITE;
    for (int k = 0; k < NUM_CHAN; k++) begin
      pair[k] = {1'b0, left_texel[k]} + {1'b0, texel_in[k]};
    end
    if (width_one) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        pair[k] = {texel_in[k], 1'b0};
      end
      have_pair = 1'b1;
    end else if (column_count[0] && (x_full <= COL_W'(tw_m1))) begin
      have_pair = 1'b1;
      x         = ADDR_W'(x_full);
    end
    if (have_pair) begin
      if (height_one) begin
        kind   = JOB_DIRECT;
        gen    = 1'b1;
        y_last = 1'b1;
      end else if (!row_count[0]) begin
        kind = JOB_WRITE;
        gen  = 1'b1;
      end else if (y_full <= ROW_W'(th_m1)) begin
        kind   = JOB_READ;
        gen    = 1'b1;
        y_last = (y_full == ROW_W'(th_m1));
      end
    end
    job_push       = accept && gen;
    job.kind       = kind;
    job.pair       = pair;
    job.end_of_row = (x == tw_m1);
    job.last       = (x == tw_m1) && y_last;
    job_x          = x;
  end

  // Step the raster position
  always_comb begin
    col_inc = WD_W'({1'b0, column_count}) + WD_W'(1);
    row_inc = CFG_W'(row_count) + CFG_W'(1);
  end

  // Hold geometry, counters and the left texel
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff    <= WD_W'(1);
      width_one    <= 1'b1;
      tw_m1        <= '0;
      height_eff   <= CFG_W'(1);
      height_one   <= 1'b1;
      th_m1        <= '0;
      column_count <= '0;
      row_count    <= '0;
      left_texel   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH: begin
          width_eff <= width_new;
          width_one <= (width_new == WD_W'(1));
          tw_m1     <= (width_new >= WD_W'(2)) ?
                       ADDR_W'((width_new >> 1) - WD_W'(1)) : '0;
        end
        REG_SOURCE_HEIGHT: begin
          height_eff <= height_new;
          height_one <= (height_new == CFG_W'(1));
          th_m1      <= (height_new >= CFG_W'(2)) ?
                        Y_W'((height_new >> 1) - CFG_W'(1)) : '0;
        end
        default: begin
        end
      endcase
      column_count <= '0;
      row_count    <= '0;
      left_texel   <= '0;
    end else if (accept) begin
      if (!width_one && !column_count[0]) begin
        left_texel <= texel_in;
      end
      if (col_inc >= width_eff) begin
        column_count <= '0;
        row_count    <= (row_inc >= height_eff) ? '0 : ROW_W'(row_inc);
      end else begin
        column_count <= COL_W'(col_inc);
      end
    end
  end

endmodule
`default_nettype wire

[src/mbd_back.sv]
`default_nettype none
module mbd_back #(
  parameter int MAX_WIDTH = 4096,
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1,
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
  localparam int OCNT_W = $clog2(mbd_pkg::OUT_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_empty,
  input  mbd_pkg::job_t     job,
  input  logic [ADDR_W-1:0] job_x,
  output logic              job_pop,
  input  logic              pop,
  output logic              empty,
  output mbd_pkg::result_t  result
);
  import mbd_pkg::*;

  // Line store of horizontal pair sums from the even row
  pair_t line_mem [LINE_DEPTH];
  pair_t line_rd;

  logic              s1_valid;
  job_t              s1_job;
  result_t           s1_result;
  logic [OCNT_W-1:0] out_count;
  logic [OCNT_W:0]   out_used;
  logic              out_full;
  logic [$bits(result_t)-1:0] out_rd;

  // Take a job only when the result queue has room for everything in flight
  assign out_used = {1'b0, out_count} + (OCNT_W + 1)'(s1_valid);
  assign job_pop  = !job_empty && !out_full && (out_used < (OCNT_W + 1)'(OUT_DEPTH));

  // Write even-row pair sums, read them back on odd rows
  always_ff @(posedge clk) begin
    if (job_pop) begin
      if (job.kind == JOB_WRITE) begin
        line_mem[job_x] <= job.pair;
      end
      line_rd <= line_mem[job_x];
      s1_job  <= job;
    end
  end

  // Mark a result in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= job_pop && (job.kind == JOB_DIRECT || job.kind == JOB_READ);
    end
  end

  // Add the stored pair and divide by four, or halve the pair for direct jobs
  always_comb begin
    logic [PAIR_W:0] sum;
    sum = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      sum = {1'b0, line_rd[k]} + {1'b0, s1_job.pair[k]};
      case (s1_job.kind)
        JOB_DIRECT: s1_result.texel[k] = s1_job.pair[k][PAIR_W-1:1];
        default:    s1_result.texel[k] = sum[PAIR_W:2];
      endcase
    end
    s1_result.end_of_row = s1_job.end_of_row;
    s1_result.last       = s1_job.last;
  end

  // Hold finished words until popped
  mbd_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (s1_valid),
    .wr_data(s1_result),
    .rd_en  (pop),
    .rd_data(out_rd),
    .full   (out_full),
    .empty  (empty),
    .count  (out_count)
  );

  assign result = result_t'(out_rd);

endmodule
`default_nettype wire

[src/mip_box_downsample.sv]
// Channel   Direction  Handshake          Word
// input     in         push / full        red_in, green_in, blue_in, alpha_in
// result    out        empty / pop        red_out .. alpha_out, end_of_row, last
// config    in         cfg_write          cfg_index, cfg_data
//
// One source texel is taken per clock while full is low; the line store takes one job per
// clock, so the sustained rate is one texel per cycle while results are popped.
// A result reaches the result ports once the texel that completes it has passed the job queue, s1 and the result queue.
// rst is synchronous and active high; it sets both dimensions to 1 and restarts the image.
// full rises when the four-word job queue fills; a stalled pop backs up through
// the four-word result queue into the job queue.
`default_nettype none
module mip_box_downsample #(
  parameter int MAX_WIDTH = 4096,
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1,
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                red_in,
  input  logic [7:0]                green_in,
  input  logic [7:0]                blue_in,
  input  logic [7:0]                alpha_in,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                red_out,
  output logic [7:0]                green_out,
  output logic [7:0]                blue_out,
  output logic [7:0]                alpha_out,
  output logic                      end_of_row,
  output logic                      last,
  input  logic                      cfg_write,
  input  mbd_pkg::cfg_index_t       cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0] cfg_data
);
  import mbd_pkg::*;

  localparam int JWORD_W = $bits(job_t) + ADDR_W;
  localparam int JCNT_W  = $clog2(JOB_DEPTH + 1);

  texel_t              texel_in;
  logic                job_push;
  job_t                front_job;
  logic [ADDR_W-1:0]   front_x;
  logic                job_full;
  logic                job_empty;
  logic                job_pop;
  logic [JCNT_W-1:0]   job_count;
  logic [JWORD_W-1:0]  job_word;
  job_t                back_job;
  logic [ADDR_W-1:0]   back_x;
  result_t             result;

  assign texel_in = {alpha_in, blue_in, green_in, red_in};
  assign full     = job_full;

  // Count and classify incoming texels
  mbd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .texel_in (texel_in),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job_full (job_full),
    .job_push (job_push),
    .job      (front_job),
    .job_x    (front_x)
  );

  // Decouple front from back
  mbd_queue #(
    .WIDTH(JWORD_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_data({front_job, front_x}),
    .rd_en  (job_pop),
    .rd_data(job_word),
    .full   (job_full),
    .empty  (job_empty),
    .count  (job_count)
  );

  assign back_job = job_t'(job_word[JWORD_W-1:ADDR_W]);
  assign back_x   = job_word[ADDR_W-1:0];

  // Line store, averaging and result queue
  mbd_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_empty(job_empty),
    .job      (back_job),
    .job_x    (back_x),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  assign red_out    = result.texel[0];
  assign green_out  = result.texel[1];
  assign blue_out   = result.texel[2];
  assign alpha_out  = result.texel[3];
  assign end_of_row = result.end_of_row;
  assign last       = result.last;

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job popped from an empty queue");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job_count != JCNT_W'(JOB_DEPTH)))
    else $error("job pushed into a full queue");

  a_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> end_of_row)
    else $error("final word not marked end of row");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule
`default_nettype wire
